// ===== hdl/aabb_affine_transform_top_macros.svh =====
`ifndef AABB_AFFINE_TRANSFORM_TOP_MACROS_SVH
`define AABB_AFFINE_TRANSFORM_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define AAT_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("aat check failed");

// antecedent implies consequent a fixed number of cycles later
`define AAT_ASSERT_DELAY(label, ante, dly, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error("aat latency check failed");

`endif

// ===== hdl/aat_pkg.sv =====
`default_nettype none

package aat_pkg;

	// fixed field widths
	localparam int COORD_W = 32;
	localparam int ROW_W   = 48;
	localparam int COEFF_W = 16;

	// register port
	localparam int DATA_W = 64;
	localparam int ADDR_W = 6;
	localparam int IDX_W  = ADDR_W - 3;

	// register indexes, 8 bytes apart
	localparam logic [IDX_W-1:0] REG_ROW_X   = 3'd0;
	localparam logic [IDX_W-1:0] REG_ROW_Y   = 3'd1;
	localparam logic [IDX_W-1:0] REG_ROW_Z   = 3'd2;
	localparam logic [IDX_W-1:0] REG_TRANS_X = 3'd3;
	localparam logic [IDX_W-1:0] REG_TRANS_Y = 3'd4;
	localparam logic [IDX_W-1:0] REG_TRANS_Z = 3'd5;

	typedef struct packed {
		logic signed [COORD_W-1:0] in_min_x;
		logic signed [COORD_W-1:0] in_min_y;
		logic signed [COORD_W-1:0] in_min_z;
		logic signed [COORD_W-1:0] in_max_x;
		logic signed [COORD_W-1:0] in_max_y;
		logic signed [COORD_W-1:0] in_max_z;
	} aat_box_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] out_min_x;
		logic signed [COORD_W-1:0] out_min_y;
		logic signed [COORD_W-1:0] out_min_z;
		logic signed [COORD_W-1:0] out_max_x;
		logic signed [COORD_W-1:0] out_max_y;
		logic signed [COORD_W-1:0] out_max_z;
		logic                      out_saturated;
	} aat_res_t;

	// transform settings, index 0 is x
	typedef struct packed {
		logic [2:0][ROW_W-1:0]   row;
		logic [2:0][COORD_W-1:0] trans;
	} aat_cfg_t;

endpackage

`default_nettype wire

// ===== hdl/aat_regs.sv =====
`default_nettype none

module aat_regs #(
	parameter int COEFF_WIDTH = aat_pkg::COEFF_W
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [aat_pkg::ADDR_W-1:0] paddr,
	input  wire logic [aat_pkg::DATA_W-1:0] pwdata,
	output logic      [aat_pkg::DATA_W-1:0] prdata,
	output aat_pkg::aat_cfg_t               cfg
);

	localparam int RW   = aat_pkg::ROW_W;
	localparam int CW   = aat_pkg::COORD_W;
	localparam int FRAC = COEFF_WIDTH - 4;

	// unit coefficient on the diagonal lane of each row
	localparam logic [63:0] ONE_0 = 64'd1 << FRAC;
	localparam logic [63:0] ONE_1 = 64'd1 << (COEFF_WIDTH + FRAC);
	localparam logic [63:0] ONE_2 = 64'd1 << (2 * COEFF_WIDTH + FRAC);

	logic [2:0][RW-1:0]        row_q;
	logic [2:0][CW-1:0]        trans_q;
	logic [aat_pkg::IDX_W-1:0] idx;
	logic                      wr_en;

	assign idx   = paddr[aat_pkg::ADDR_W-1:3];
	assign wr_en = psel && penable && pwrite;

	// register writes on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0]   <= ONE_0[RW-1:0];
			row_q[1]   <= ONE_1[RW-1:0];
			row_q[2]   <= ONE_2[RW-1:0];
			trans_q[0] <= '0;
			trans_q[1] <= '0;
			trans_q[2] <= '0;
		end else if (wr_en) begin
			case (idx)
				aat_pkg::REG_ROW_X:   row_q[0]   <= pwdata[RW-1:0];
				aat_pkg::REG_ROW_Y:   row_q[1]   <= pwdata[RW-1:0];
				aat_pkg::REG_ROW_Z:   row_q[2]   <= pwdata[RW-1:0];
				aat_pkg::REG_TRANS_X: trans_q[0] <= pwdata[CW-1:0];
				aat_pkg::REG_TRANS_Y: trans_q[1] <= pwdata[CW-1:0];
				aat_pkg::REG_TRANS_Z: trans_q[2] <= pwdata[CW-1:0];
				default: ;
			endcase
		end
	end

	// read mux, translations sign extended
	always_comb begin
		case (idx)
			aat_pkg::REG_ROW_X:   prdata = aat_pkg::DATA_W'(row_q[0]);
			aat_pkg::REG_ROW_Y:   prdata = aat_pkg::DATA_W'(row_q[1]);
			aat_pkg::REG_ROW_Z:   prdata = aat_pkg::DATA_W'(row_q[2]);
			aat_pkg::REG_TRANS_X: prdata = aat_pkg::DATA_W'($signed(trans_q[0]));
			aat_pkg::REG_TRANS_Y: prdata = aat_pkg::DATA_W'($signed(trans_q[1]));
			aat_pkg::REG_TRANS_Z: prdata = aat_pkg::DATA_W'($signed(trans_q[2]));
			default:              prdata = '0;
		endcase
	end

	assign cfg.row   = row_q;
	assign cfg.trans = trans_q;

endmodule

`default_nettype wire

// ===== hdl/aat_axis.sv =====
`default_nettype none

// one output axis: the min and max over corners split per input lane, as each
// product term depends on one coordinate only, and clamping keeps the order
module aat_axis #(
	parameter int COEFF_WIDTH = aat_pkg::COEFF_W
) (
	input  wire logic                             clk,
	input  wire logic [2:0][aat_pkg::COORD_W-1:0] min_pt,
	input  wire logic [2:0][aat_pkg::COORD_W-1:0] max_pt,
	input  wire logic [aat_pkg::ROW_W-1:0]        row,
	input  wire logic [aat_pkg::COORD_W-1:0]      trans,
	output logic      [aat_pkg::COORD_W-1:0]      lo_s4,
	output logic      [aat_pkg::COORD_W-1:0]      hi_s4,
	output logic                                  sat_s4
);

	localparam int CW   = aat_pkg::COORD_W;
	localparam int RW   = aat_pkg::ROW_W;
	localparam int KW   = COEFF_WIDTH;
	localparam int FRAC = KW - 4;
	localparam int PW   = CW + KW;
	localparam int TW   = PW - FRAC;
	localparam int SW   = TW + 2;

	localparam logic signed [SW-1:0] SAT_HI = {{(SW - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
	localparam logic signed [SW-1:0] SAT_LO = {{(SW - CW + 1){1'b1}}, {(CW - 1){1'b0}}};

	logic [3*KW+RW-1:0]     row_ext;
	logic signed [KW-1:0]   coef    [3];
	logic signed [PW-1:0]   prod_lo [3];
	logic signed [PW-1:0]   prod_hi [3];
	logic signed [TW-1:0]   term_lo_s2 [3];
	logic signed [TW-1:0]   term_hi_s2 [3];
	logic signed [TW-1:0]   tmin_s3 [3];
	logic signed [TW-1:0]   tmax_s3 [3];
	logic signed [SW-1:0]   sum_lo;
	logic signed [SW-1:0]   sum_hi;

	// lanes lying past the register read as zero
	assign row_ext = {{(3 * KW){1'b0}}, row};

	// products of each lane with both box extremes
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			coef[c]    = row_ext[c*KW +: KW];
			prod_lo[c] = coef[c] * $signed(min_pt[c]);
			prod_hi[c] = coef[c] * $signed(max_pt[c]);
		end
	end

	// truncating shift is a plain bit selection
	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			term_lo_s2[c] <= prod_lo[c][PW-1:FRAC];
			term_hi_s2[c] <= prod_hi[c][PW-1:FRAC];
		end
	end

	// smaller and larger term of each lane
	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			if (term_lo_s2[c] < term_hi_s2[c]) begin
				tmin_s3[c] <= term_lo_s2[c];
				tmax_s3[c] <= term_hi_s2[c];
			end else begin
				tmin_s3[c] <= term_hi_s2[c];
				tmax_s3[c] <= term_lo_s2[c];
			end
		end
	end

	// extreme sums plus translation
	always_comb begin
		sum_lo = SW'(tmin_s3[0]) + SW'(tmin_s3[1]) + SW'(tmin_s3[2]) + SW'($signed(trans));
		sum_hi = SW'(tmax_s3[0]) + SW'(tmax_s3[1]) + SW'(tmax_s3[2]) + SW'($signed(trans));
	end

	// clamp to coordinate range and flag
	always_ff @(posedge clk) begin
		if (sum_lo < SAT_LO) begin
			lo_s4 <= SAT_LO[CW-1:0];
		end else if (sum_lo > SAT_HI) begin
			lo_s4 <= SAT_HI[CW-1:0];
		end else begin
			lo_s4 <= sum_lo[CW-1:0];
		end
		if (sum_hi > SAT_HI) begin
			hi_s4 <= SAT_HI[CW-1:0];
		end else if (sum_hi < SAT_LO) begin
			hi_s4 <= SAT_LO[CW-1:0];
		end else begin
			hi_s4 <= sum_hi[CW-1:0];
		end
		sat_s4 <= (sum_lo < SAT_LO) || (sum_hi > SAT_HI);
	end

endmodule

`default_nettype wire

// ===== hdl/aabb_affine_transform_top.sv =====
// a request accepted at a clock edge is held in the input register, then passes
// the product, lane min/max and sum and clamp registers to its result strobe
// throughput: one request per cycle; busy stays low, the four-stage datapath
// (input, product, lane min/max, sum and clamp) takes a request every cycle
// reset: arst_n clears the stage valid bits and loads the identity transform
`default_nettype none

`include "aabb_affine_transform_top_macros.svh"

module aabb_affine_transform_top #(
	parameter int COEFF_WIDTH = aat_pkg::COEFF_W
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire aat_pkg::aat_box_t          request,
	output logic                            result_valid,
	output aat_pkg::aat_res_t               result,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [aat_pkg::ADDR_W-1:0] paddr,
	input  wire logic [aat_pkg::DATA_W-1:0] pwdata,
	output logic      [aat_pkg::DATA_W-1:0] prdata,
	output logic                            pready
);

	aat_pkg::aat_cfg_t                   cfg;
	aat_pkg::aat_box_t                   box_s1;
	logic                                v_s1, v_s2, v_s3, v_s4;
	logic [2:0][aat_pkg::COORD_W-1:0]    min_pt, max_pt;
	logic [2:0][aat_pkg::COORD_W-1:0]    lo_s4, hi_s4;
	logic [2:0]                          sat_s4;

	assign busy   = 1'b0;
	assign pready = 1'b1;

	aat_regs #(
		.COEFF_WIDTH(COEFF_WIDTH)
	) u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.cfg    (cfg)
	);

	// input register
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			box_s1 <= request;
		end
	end

	// stage valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign min_pt = {box_s1.in_min_z, box_s1.in_min_y, box_s1.in_min_x};
	assign max_pt = {box_s1.in_max_z, box_s1.in_max_y, box_s1.in_max_x};

	// one datapath per output axis
	for (genvar a = 0; a < 3; a++) begin : g_axis
		aat_axis #(
			.COEFF_WIDTH(COEFF_WIDTH)
		) u_axis (
			.clk   (clk),
			.min_pt(min_pt),
			.max_pt(max_pt),
			.row   (cfg.row[a]),
			.trans (cfg.trans[a]),
			.lo_s4 (lo_s4[a]),
			.hi_s4 (hi_s4[a]),
			.sat_s4(sat_s4[a])
		);
	end

	// result assembly
	assign result_valid         = v_s4;
	assign result.out_min_x     = lo_s4[0];
	assign result.out_min_y     = lo_s4[1];
	assign result.out_min_z     = lo_s4[2];
	assign result.out_max_x     = hi_s4[0];
	assign result.out_max_y     = hi_s4[1];
	assign result.out_max_z     = hi_s4[2];
	assign result.out_saturated = |sat_s4;

	// checks
	`AAT_ASSERT_DELAY(a_req_to_result, start && !busy, 4, result_valid)
	`AAT_ASSERT_IMPLIES(a_result_has_req, result_valid, $past(start && !busy, 4))
	`AAT_ASSERT_IMPLIES(a_order_x, result_valid, result.out_min_x <= result.out_max_x)
	`AAT_ASSERT_IMPLIES(a_order_y, result_valid, result.out_min_y <= result.out_max_y)
	`AAT_ASSERT_IMPLIES(a_order_z, result_valid, result.out_min_z <= result.out_max_z)

endmodule

`default_nettype wire
